// ----- sv/ale_pkg.sv -----
// Shared types and constants for the array list engine.
package ale_pkg;

	localparam int CAPACITY = 256;
	localparam int AW       = $clog2(CAPACITY);
	localparam int LEN_W    = 9;
	localparam int DATA_W   = 32;

	localparam logic [3:0] OP_HEAD_INS = 4'd0;
	localparam logic [3:0] OP_TAIL_INS = 4'd1;
	localparam logic [3:0] OP_POS_INS  = 4'd2;
	localparam logic [3:0] OP_READ     = 4'd3;
	localparam logic [3:0] OP_FIND     = 4'd4;
	localparam logic [3:0] OP_DEL_POS  = 4'd5;
	localparam logic [3:0] OP_DEL_VAL  = 4'd6;
	localparam logic [3:0] OP_SORT     = 4'd7;
	localparam logic [3:0] OP_REVERSE  = 4'd8;
	localparam logic [3:0] OP_CLEAR    = 4'd9;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_BADPOS   = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [3:0]        op;
		logic [31:0]       value;
		logic [LEN_W-1:0]  position;
		logic              sort_ascending;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [31:0]       read_value;
		logic [LEN_W-1:0]  found_position;
		logic [LEN_W-1:0]  list_length;
	} rsp_t;

	typedef struct packed {
		logic start;
		req_t req;
	} seq_cmd_t;

	typedef struct packed {
		logic done;
		logic idle;
		rsp_t rsp;
	} seq_res_t;

endpackage

// ----- sv/ale_seq.sv -----
// List store and operation sequencer: reads, shifts, searches, sorts and reverses the store.
module ale_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  ale_pkg::seq_cmd_t  cmd,
	input  logic               slot_free,
	output ale_pkg::seq_res_t  res
);

	typedef enum logic [19:0] {
		S_IDLE      = 20'h00001,
		S_INS_RD    = 20'h00002,
		S_INS_WR    = 20'h00004,
		S_INS_PUT   = 20'h00008,
		S_READ_A    = 20'h00010,
		S_READ_D    = 20'h00020,
		S_DEL_RD    = 20'h00040,
		S_DEL_WR    = 20'h00080,
		S_FIND_RD   = 20'h00100,
		S_FIND_CHK  = 20'h00200,
		S_SRT_START = 20'h00400,
		S_SRT_LOAD  = 20'h00800,
		S_SRT_RD    = 20'h01000,
		S_SRT_CMP   = 20'h02000,
		S_SRT_END   = 20'h04000,
		S_REV_RDA   = 20'h08000,
		S_REV_RDB   = 20'h10000,
		S_REV_WA    = 20'h20000,
		S_REV_WB    = 20'h40000,
		S_FIN       = 20'h80000
	} state_t;

	localparam int AW    = ale_pkg::AW;
	localparam int LEN_W = ale_pkg::LEN_W;
	localparam int DW    = ale_pkg::DATA_W;

	logic [DW-1:0] mem [ale_pkg::CAPACITY];
	logic [DW-1:0] rdata_q;

	state_t            state_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  idx_q;
	logic [LEN_W-1:0]  kdx_q;
	logic [LEN_W-1:0]  pass_q;
	logic [DW-1:0]     cur_q;
	logic [DW-1:0]     val_q;
	logic [3:0]        op_q;
	logic              asc_q;
	logic [2:0]        status_q;
	logic [DW-1:0]     rdv_q;
	logic [LEN_W-1:0]  fp_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [DW-1:0]     wdata;

	logic [LEN_W-1:0]  idx_p1;
	logic [LEN_W-1:0]  idx_p2;
	logic [LEN_W-1:0]  idx_m1;
	logic [LEN_W-1:0]  cnt_m1;
	logic [LEN_W-1:0]  half;
	logic [LEN_W-1:0]  pos;
	logic [LEN_W-1:0]  pos_m1;
	logic [LEN_W-1:0]  ins_k;
	logic              is_full;
	logic              swap;

	assign idx_p1  = idx_q + LEN_W'(1);
	assign idx_p2  = idx_q + LEN_W'(2);
	assign idx_m1  = idx_q - LEN_W'(1);
	assign cnt_m1  = cnt_q - LEN_W'(1);
	assign half    = cnt_q >> 1;
	assign pos     = cmd.req.position;
	assign pos_m1  = pos - LEN_W'(1);
	assign is_full = (cnt_q == LEN_W'(ale_pkg::CAPACITY));
	assign swap    = asc_q ? ($signed(cur_q) > $signed(rdata_q))
	                       : ($signed(rdata_q) > $signed(cur_q));

	always_comb begin
		case (cmd.req.op)
			ale_pkg::OP_HEAD_INS: ins_k = '0;
			ale_pkg::OP_TAIL_INS: ins_k = cnt_q;
			default:              ins_k = pos_m1;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata_q;
		raddr = idx_q[AW-1:0];
		case (state_q)
			S_INS_RD:    raddr = idx_m1[AW-1:0];
			S_INS_WR:    we = 1'b1;
			S_INS_PUT: begin
				we    = 1'b1;
				waddr = kdx_q[AW-1:0];
				wdata = val_q;
			end
			S_DEL_RD:    raddr = idx_p1[AW-1:0];
			S_DEL_WR:    we = 1'b1;
			S_SRT_START: raddr = '0;
			S_SRT_RD:    raddr = idx_p1[AW-1:0];
			S_SRT_CMP: begin
				we = 1'b1;
				if (!swap) begin
					wdata = cur_q;
				end
			end
			S_SRT_END: begin
				we    = 1'b1;
				waddr = cnt_m1[AW-1:0];
				wdata = cur_q;
			end
			S_REV_RDB:   raddr = kdx_q[AW-1:0];
			S_REV_WA:    we = 1'b1;
			S_REV_WB: begin
				we    = 1'b1;
				waddr = kdx_q[AW-1:0];
				wdata = cur_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			kdx_q    <= '0;
			pass_q   <= '0;
			cur_q    <= '0;
			val_q    <= '0;
			op_q     <= ale_pkg::OP_HEAD_INS;
			asc_q    <= 1'b0;
			status_q <= ale_pkg::ST_OK;
			rdv_q    <= '0;
			fp_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						op_q     <= cmd.req.op;
						val_q    <= cmd.req.value;
						asc_q    <= cmd.req.sort_ascending;
						status_q <= ale_pkg::ST_OK;
						rdv_q    <= '0;
						fp_q     <= '0;
						state_q  <= S_FIN;
						case (cmd.req.op)
							ale_pkg::OP_HEAD_INS, ale_pkg::OP_TAIL_INS,
							ale_pkg::OP_POS_INS: begin
								if (is_full) begin
									status_q <= ale_pkg::ST_FULL;
								end else if (cmd.req.op == ale_pkg::OP_POS_INS &&
								             (pos == '0 || pos > cnt_q + LEN_W'(1))) begin
									status_q <= ale_pkg::ST_BADPOS;
								end else begin
									kdx_q   <= ins_k;
									idx_q   <= cnt_q;
									state_q <= (cnt_q > ins_k) ? S_INS_RD : S_INS_PUT;
								end
							end
							ale_pkg::OP_READ, ale_pkg::OP_DEL_POS: begin
								if (cnt_q == '0) begin
									status_q <= ale_pkg::ST_EMPTY;
								end else if (pos == '0 || pos > cnt_q) begin
									status_q <= ale_pkg::ST_BADPOS;
								end else if (cmd.req.op == ale_pkg::OP_READ) begin
									idx_q   <= pos_m1;
									state_q <= S_READ_A;
								end else begin
									idx_q   <= pos_m1;
									fp_q    <= pos;
									state_q <= S_DEL_RD;
								end
							end
							ale_pkg::OP_FIND, ale_pkg::OP_DEL_VAL: begin
								if (cnt_q == '0) begin
									status_q <= ale_pkg::ST_EMPTY;
								end else begin
									idx_q   <= '0;
									state_q <= S_FIND_RD;
								end
							end
							ale_pkg::OP_SORT: begin
								if (cnt_q > LEN_W'(1)) begin
									pass_q  <= LEN_W'(1);
									state_q <= S_SRT_START;
								end
							end
							ale_pkg::OP_REVERSE: begin
								if (half != '0) begin
									idx_q   <= '0;
									kdx_q   <= cnt_m1;
									state_q <= S_REV_RDA;
								end
							end
							ale_pkg::OP_CLEAR: cnt_q <= '0;
							default: ;
						endcase
					end
				end
				S_INS_RD: state_q <= S_INS_WR;
				S_INS_WR: begin
					idx_q   <= idx_m1;
					state_q <= (idx_m1 > kdx_q) ? S_INS_RD : S_INS_PUT;
				end
				S_INS_PUT: begin
					cnt_q   <= cnt_q + LEN_W'(1);
					state_q <= S_FIN;
				end
				S_READ_A: state_q <= S_READ_D;
				S_READ_D: begin
					rdv_q   <= rdata_q;
					state_q <= S_FIN;
				end
				S_DEL_RD: begin
					if (idx_p1 < cnt_q) begin
						state_q <= S_DEL_WR;
					end else begin
						cnt_q   <= cnt_m1;
						state_q <= S_FIN;
					end
				end
				S_DEL_WR: begin
					idx_q   <= idx_p1;
					state_q <= S_DEL_RD;
				end
				S_FIND_RD: state_q <= S_FIND_CHK;
				S_FIND_CHK: begin
					if (rdata_q == val_q) begin
						fp_q    <= idx_p1;
						state_q <= (op_q == ale_pkg::OP_DEL_VAL) ? S_DEL_RD : S_FIN;
					end else if (idx_p1 >= cnt_q) begin
						status_q <= ale_pkg::ST_NOTFOUND;
						state_q  <= S_FIN;
					end else begin
						idx_q   <= idx_p1;
						state_q <= S_FIND_RD;
					end
				end
				S_SRT_START: begin
					idx_q   <= '0;
					state_q <= S_SRT_LOAD;
				end
				S_SRT_LOAD: begin
					cur_q   <= rdata_q;
					state_q <= S_SRT_RD;
				end
				S_SRT_RD: state_q <= S_SRT_CMP;
				S_SRT_CMP: begin
					if (!swap) begin
						cur_q <= rdata_q;
					end
					if (idx_p2 < cnt_q) begin
						idx_q   <= idx_p1;
						state_q <= S_SRT_RD;
					end else begin
						state_q <= S_SRT_END;
					end
				end
				S_SRT_END: begin
					if (pass_q + LEN_W'(1) < cnt_q) begin
						pass_q  <= pass_q + LEN_W'(1);
						state_q <= S_SRT_START;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_REV_RDA: state_q <= S_REV_RDB;
				S_REV_RDB: begin
					cur_q   <= rdata_q;
					state_q <= S_REV_WA;
				end
				S_REV_WA: state_q <= S_REV_WB;
				S_REV_WB: begin
					idx_q   <= idx_p1;
					kdx_q   <= kdx_q - LEN_W'(1);
					state_q <= (idx_p1 < half) ? S_REV_RDA : S_FIN;
				end
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.done               = (state_q == S_FIN) && slot_free;
	assign res.idle               = (state_q == S_IDLE);
	assign res.rsp.status         = status_q;
	assign res.rsp.read_value     = rdv_q;
	assign res.rsp.found_position = fp_q;
	assign res.rsp.list_length    = cnt_q;

endmodule

// ----- sv/array_list_engine.sv -----
// Top level of the array list engine: item handshakes and result register.
//
// Ordered list of up to 256 signed 32-bit values held in one single-port-write
// RAM with a registered read. One item is worked at a time; a new item is taken
// once the previous one has finished, while its result may still wait in the
// output register. Clear and rejected items go straight to the result. With k the
// 0-based slot involved: an insert shifts the entries from the tail down to slot
// k up by one, then writes the value; a delete shifts the entries above slot k
// down by one; find and delete by value scan from slot 0; reverse swaps pairs
// from both ends inward; sort runs one bubble pass over the whole list per entry
// but one. The RAM gives one read and one write per cycle. No clearing pass
// after reset: the list starts empty.
module array_list_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ale_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ale_pkg::rsp_t  rsp
);

	ale_pkg::seq_cmd_t  cmd;
	ale_pkg::seq_res_t  res;
	logic               rsp_valid_q;
	ale_pkg::rsp_t      rsp_q;
	logic               slot_free;

	assign req_stall = !res.idle;
	assign cmd.start = req_valid && res.idle;
	assign cmd.req   = req;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	ale_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.slot_free (slot_free),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res.done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			rsp_q <= res.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
